/* src/collatz_trajectory_checker_macros.svh */
// Assertion macros for the collatz trajectory checker.
`ifndef COLLATZ_TRAJECTORY_CHECKER_MACROS_SVH
`define COLLATZ_TRAJECTORY_CHECKER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, held off during reset.
`define CTC_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication, held off during reset.
`define CTC_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define CTC_ASSERT_IMP(label, ck, rn, ante, cons)
`define CTC_ASSERT_NXT(label, ck, rn, ante, cons)
`endif
`endif

/* src/cltz_pkg.sv */
// Shared constants, codes and structs for the collatz trajectory checker.
package cltz_pkg;

    localparam int WORDS       = 8;
    localparam int DIGIT_W     = 64;
    localparam int NUM_W       = DIGIT_W * WORDS;
    localparam int WIDX_W      = $clog2(WORDS);
    localparam int BIT_W       = $clog2(DIGIT_W);
    localparam int POS_W       = $clog2(NUM_W);
    localparam int SHIFT_W     = 9;
    localparam int KSH_W       = SHIFT_W + 1;
    localparam int LIMIT_W     = 24;
    localparam int STEPS_W     = 25;
    localparam int PEAK_W      = 9;
    localparam int BEST_PEAK_W = 10;
    localparam int MULT_W      = 64;
    localparam int FLAG_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 24;

    localparam logic [LIMIT_W-1:0]   LIMIT_RESET      = 24'd500000;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_AMOUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ONE      = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_LIMIT    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INIT,
        OP_TRIPLE,
        OP_EVAL,
        OP_DROP,
        OP_FUNNEL
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_TRIPLE,
        S_EVAL,
        S_DROP,
        S_FUNNEL,
        S_CHECK,
        S_DONE
    } state_t;

    typedef struct packed {
        op_t              op;
        logic             first;
        logic             last;
        logic [WIDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic              is_one;
        logic              overflow;
        logic [POS_W-1:0]  top_pos;
        logic [WIDX_W-1:0] drop_words;
    } dstat_t;

    typedef struct packed {
        status_t            status;
        logic [STEPS_W-1:0] steps;
        logic [POS_W-1:0]   peak;
        logic [MULT_W-1:0]  mult;
    } res_t;

endpackage

/* src/cltz_digit.sv */
// Word-serial number store: start value, 3n+1 and right shift, one word a cycle.
module cltz_digit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cltz_pkg::cmd_t             cmd,
    input  logic [cltz_pkg::KSH_W-1:0] k,
    input  logic [cltz_pkg::MULT_W-1:0] m,
    output cltz_pkg::dstat_t           dstat
);
    import cltz_pkg::*;

    localparam int WSH_W = KSH_W - BIT_W;

    // highest set bit, binary search
    function automatic logic [BIT_W-1:0] msb_pos(input logic [DIGIT_W-1:0] w);
        logic [DIGIT_W-1:0] v;
        logic [BIT_W-1:0]   p;
        v = w;
        p = '0;
        for (int s = BIT_W - 1; s >= 0; s--) begin
            if ((v >> (1 << s)) != '0) begin
                p[s] = 1'b1;
                v    = v >> (1 << s);
            end
        end
        return p;
    endfunction

    // trailing zeros, binary search
    function automatic logic [BIT_W-1:0] lsb_pos(input logic [DIGIT_W-1:0] w);
        logic [DIGIT_W-1:0] v;
        logic [BIT_W-1:0]   p;
        v = w;
        p = '0;
        for (int s = BIT_W - 1; s >= 0; s--) begin
            if ((v & ({DIGIT_W{1'b1}} >> (DIGIT_W - (1 << s)))) == '0) begin
                p[s] = 1'b1;
                v    = v >> (1 << s);
            end
        end
        return p;
    endfunction

    logic [DIGIT_W-1:0] num_reg [WORDS];
    logic [DIGIT_W-1:0] push;
    logic               do_shift;

    logic               borrow_reg, borrow_next;
    logic [1:0]         carry_reg, carry_next;
    logic               one_reg, one_next;
    logic [WIDX_W-1:0]  hi_idx_reg, hi_idx_next;
    logic [DIGIT_W-1:0] hi_word_reg, hi_word_next;
    logic               lo_found_reg, lo_found_next;
    logic [WIDX_W-1:0]  lo_idx_reg, lo_idx_next;
    logic [DIGIT_W-1:0] lo_word_reg, lo_word_next;
    logic [BIT_W-1:0]   shamt_reg, shamt_next;

    logic [WSH_W-1:0]   wsh;
    logic [BIT_W-1:0]   bsh;
    logic [DIGIT_W-1:0] gen;
    logic               borrow_in;
    logic [1:0]         carry_in;
    logic [DIGIT_W+1:0] tsum;
    logic [DIGIT_W-1:0] nxt;
    logic               lo_found_in;

    assign wsh = k[KSH_W-1:BIT_W];
    assign bsh = k[BIT_W-1:0];

    always_comb
    begin
        gen = '0;
        if (WSH_W'(cmd.idx) == wsh) begin
            gen = m << bsh;
        end else if (bsh != '0 && (WSH_W + 1)'(cmd.idx) == ({1'b0, wsh} + 1'b1)) begin
            gen = m >> ((BIT_W + 1)'(DIGIT_W) - {1'b0, bsh});
        end
    end

    assign borrow_in   = cmd.first ? 1'b1 : borrow_reg;
    assign carry_in    = cmd.first ? 2'd1 : carry_reg;
    assign lo_found_in = cmd.first ? 1'b0 : lo_found_reg;
    assign tsum        = {2'b00, num_reg[0]} + {1'b0, num_reg[0], 1'b0}
                       + {{DIGIT_W{1'b0}}, carry_in};
    assign nxt         = cmd.last ? '0 : num_reg[1];

    always_comb
    begin
        push          = '0;
        do_shift      = 1'b0;
        borrow_next   = borrow_reg;
        carry_next    = carry_reg;
        one_next      = one_reg;
        hi_idx_next   = hi_idx_reg;
        hi_word_next  = hi_word_reg;
        lo_found_next = lo_found_reg;
        lo_idx_next   = lo_idx_reg;
        lo_word_next  = lo_word_reg;
        shamt_next    = shamt_reg;
        case (cmd.op)
            OP_INIT:
            begin
                do_shift    = 1'b1;
                push        = gen - DIGIT_W'(borrow_in);
                borrow_next = borrow_in && (gen == '0);
            end
            OP_TRIPLE:
            begin
                do_shift   = 1'b1;
                push       = tsum[DIGIT_W-1:0];
                carry_next = tsum[DIGIT_W+1:DIGIT_W];
                if (cmd.first || push != '0) begin
                    hi_idx_next  = cmd.idx;
                    hi_word_next = push;
                end
                lo_found_next = lo_found_in;
                if (!lo_found_in && push != '0) begin
                    lo_found_next = 1'b1;
                    lo_idx_next   = cmd.idx;
                    lo_word_next  = push;
                end
            end
            OP_EVAL:
            begin
                shamt_next = lsb_pos(lo_word_reg);
            end
            OP_DROP:
            begin
                do_shift = 1'b1;
                push     = '0;
            end
            OP_FUNNEL:
            begin
                do_shift = 1'b1;
                if (shamt_reg == '0) begin
                    push = num_reg[0];
                end else begin
                    push = (num_reg[0] >> shamt_reg)
                         | (nxt << ((BIT_W + 1)'(DIGIT_W) - {1'b0, shamt_reg}));
                end
            end
            default:
            begin
                do_shift = 1'b0;
            end
        endcase
        // words leave in index order during start and shift passes
        if (cmd.op == OP_INIT || cmd.op == OP_FUNNEL) begin
            one_next = (cmd.first ? 1'b1 : one_reg)
                     && (push == ((cmd.idx == '0) ? DIGIT_W'(1) : '0));
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_shift) begin
            for (int i = 0; i < WORDS - 1; i++) begin
                num_reg[i] <= num_reg[i+1];
            end
            num_reg[WORDS-1] <= push;
        end
        hi_word_reg <= hi_word_next;
        lo_word_reg <= lo_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            borrow_reg   <= 1'b0;
            carry_reg    <= '0;
            one_reg      <= 1'b0;
            hi_idx_reg   <= '0;
            lo_found_reg <= 1'b0;
            lo_idx_reg   <= '0;
            shamt_reg    <= '0;
        end else begin
            borrow_reg   <= borrow_next;
            carry_reg    <= carry_next;
            one_reg      <= one_next;
            hi_idx_reg   <= hi_idx_next;
            lo_found_reg <= lo_found_next;
            lo_idx_reg   <= lo_idx_next;
            shamt_reg    <= shamt_next;
        end
    end

    assign dstat.is_one     = one_reg;
    assign dstat.overflow   = (carry_reg != '0);
    assign dstat.top_pos    = {hi_idx_reg, msb_pos(hi_word_reg)};
    assign dstat.drop_words = lo_idx_reg;

endmodule

/* src/cltz_ctrl.sv */
// Sequencer: configuration, pass control, step count and peak tracking.
module cltz_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cltz_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cltz_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [cltz_pkg::MULT_W-1:0]     start_multiplier,
    input  cltz_pkg::dstat_t                dstat,
    input  logic                            res_free,
    output cltz_pkg::cmd_t                  cmd,
    output logic [cltz_pkg::KSH_W-1:0]      k,
    output logic [cltz_pkg::MULT_W-1:0]     m,
    output logic                            load,
    output cltz_pkg::res_t                  res
);
    import cltz_pkg::*;

    state_t              state_reg, state_next;
    logic [WIDX_W-1:0]   cnt_reg, cnt_next;
    logic [STEPS_W-1:0]  steps_reg, steps_next;
    logic [POS_W-1:0]    peak_reg, peak_next;
    status_t             status_reg, status_next;
    logic [MULT_W-1:0]   m_reg, m_next;
    logic [SHIFT_W-1:0]  shift_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    logic                cnt_last;
    logic [STEPS_W-1:0]  steps_inc;
    logic                over_limit;
    logic                drop_done;

    assign cnt_last   = (cnt_reg == WIDX_W'(WORDS - 1));
    assign steps_inc  = steps_reg + 1'b1;
    assign over_limit = (steps_inc > {1'b0, limit_reg});
    assign drop_done  = (WIDX_W'(cnt_reg + 1'b1) == dstat.drop_words);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            shift_reg <= '0;
            limit_reg <= LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SHIFT_AMOUNT: shift_reg <= cfg_data[SHIFT_W-1:0];
                REG_STEP_LIMIT:   limit_reg <= cfg_data[LIMIT_W-1:0];
                default:          shift_reg <= shift_reg;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_INIT;
            S_INIT:   if (cnt_last) state_next = S_CHECK;
            S_TRIPLE: if (cnt_last) state_next = S_EVAL;
            S_EVAL:
            begin
                if (dstat.overflow || over_limit) begin
                    state_next = S_DONE;
                end else if (dstat.drop_words == '0) begin
                    state_next = S_FUNNEL;
                end else begin
                    state_next = S_DROP;
                end
            end
            S_DROP:   if (drop_done) state_next = S_FUNNEL;
            S_FUNNEL: if (cnt_last) state_next = S_CHECK;
            S_CHECK:  state_next = dstat.is_one ? S_DONE : S_TRIPLE;
            S_DONE:   if (res_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = 1'b0;
        load      = 1'b0;
        cmd.op    = OP_HOLD;
        cmd.first = (cnt_reg == '0);
        cmd.last  = cnt_last;
        cmd.idx   = cnt_reg;
        case (state_reg)
            S_IDLE:   in_ready = 1'b1;
            S_INIT:   cmd.op   = OP_INIT;
            S_TRIPLE: cmd.op   = OP_TRIPLE;
            S_EVAL:   cmd.op   = OP_EVAL;
            S_DROP:   cmd.op   = OP_DROP;
            S_FUNNEL: cmd.op   = OP_FUNNEL;
            S_DONE:   load     = res_free;
            default:  cmd.op   = OP_HOLD;
        endcase
    end

    // counters and per-item bookkeeping
    always_comb
    begin
        cnt_next    = cnt_reg;
        steps_next  = steps_reg;
        peak_next   = peak_reg;
        status_next = status_reg;
        m_next      = m_reg;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next    = '0;
                steps_next  = '0;
                peak_next   = '0;
                status_next = ST_ONE;
                m_next      = start_multiplier;
            end
            S_INIT, S_TRIPLE, S_FUNNEL:
            begin
                cnt_next = cnt_last ? '0 : WIDX_W'(cnt_reg + 1'b1);
            end
            S_EVAL:
            begin
                cnt_next = '0;
                if (dstat.overflow) begin
                    status_next = ST_OVERFLOW;
                end else begin
                    if (dstat.top_pos > peak_reg) begin
                        peak_next = dstat.top_pos;
                    end
                    steps_next = steps_inc;
                    if (over_limit) begin
                        status_next = ST_LIMIT;
                    end
                end
            end
            S_DROP:
            begin
                cnt_next = drop_done ? '0 : WIDX_W'(cnt_reg + 1'b1);
            end
            S_CHECK:
            begin
                cnt_next = '0;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            steps_reg  <= '0;
            peak_reg   <= '0;
            status_reg <= ST_ONE;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            steps_reg  <= steps_next;
            peak_reg   <= peak_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg <= m_next;
    end

    assign k          = KSH_W'(shift_reg) + 1'b1;
    assign m          = m_reg;
    assign res.status = status_reg;
    assign res.steps  = steps_reg;
    assign res.peak   = peak_reg;
    assign res.mult   = m_reg;

endmodule

/* src/cltz_stats.sv */
// Running best, flagged count and the result output register.
module cltz_stats (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  cltz_pkg::res_t                    res,
    output logic                              res_free,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [cltz_pkg::STATUS_W-1:0]     status,
    output logic [cltz_pkg::STEPS_W-1:0]      step_count,
    output logic [cltz_pkg::PEAK_W-1:0]       peak_bit_index,
    output logic [cltz_pkg::LIMIT_W-1:0]      best_steps,
    output logic [cltz_pkg::MULT_W-1:0]       best_multiplier,
    output logic [cltz_pkg::BEST_PEAK_W-1:0]  best_peak_bits,
    output logic [cltz_pkg::FLAG_W-1:0]       flagged_count
);
    import cltz_pkg::*;

    logic                   valid_reg;
    status_t                status_reg;
    logic [STEPS_W-1:0]     steps_reg;
    logic [PEAK_W-1:0]      peak_reg;
    logic [LIMIT_W-1:0]     best_steps_reg, best_steps_next;
    logic [MULT_W-1:0]      best_mult_reg, best_mult_next;
    logic [BEST_PEAK_W-1:0] best_peak_reg, best_peak_next;
    logic [FLAG_W-1:0]      flag_reg, flag_next;

    assign res_free = !valid_reg || out_ready;

    always_comb
    begin
        best_steps_next = best_steps_reg;
        best_mult_next  = best_mult_reg;
        best_peak_next  = best_peak_reg;
        flag_next       = flag_reg;
        if (res.status != ST_ONE) begin
            if (flag_reg != '1) begin
                flag_next = flag_reg + 1'b1;
            end
        end else if (res.steps > {1'b0, best_steps_reg}) begin
            best_steps_next = res.steps[LIMIT_W-1:0];
            best_mult_next  = res.mult;
            best_peak_next  = BEST_PEAK_W'(res.peak) + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg      <= 1'b0;
            best_steps_reg <= '0;
            best_mult_reg  <= '0;
            best_peak_reg  <= '0;
            flag_reg       <= '0;
        end else begin
            if (load) begin
                valid_reg      <= 1'b1;
                best_steps_reg <= best_steps_next;
                best_mult_reg  <= best_mult_next;
                best_peak_reg  <= best_peak_next;
                flag_reg       <= flag_next;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            status_reg <= res.status;
            steps_reg  <= res.steps;
            peak_reg   <= PEAK_W'(res.peak);
        end
    end

    assign out_valid       = valid_reg;
    assign status          = status_reg;
    assign step_count      = steps_reg;
    assign peak_bit_index  = peak_reg;
    assign best_steps      = best_steps_reg;
    assign best_multiplier = best_mult_reg;
    assign best_peak_bits  = best_peak_reg;
    assign flagged_count   = flag_reg;

endmodule

/* src/collatz_trajectory_checker.sv */
// Top level of the collatz trajectory checker.
//
// Usage: each input transfer carries a 64-bit multiplier m; the block builds
// n = m * 2^(shift_amount+1) - 1 in a 512-bit word store and runs the odd
// step n = (3n+1) >> ctz until n is one, the 3n+1 carries out of 512 bits
// (status 1) or the step count passes step_limit (status 2).
// Every input transfer gives exactly one output transfer, carrying the
// item's status, step count and peak bit, plus the running best and the
// saturating flagged count as they stand after this item.
// Per item: accept, a start-value pass over the words and a check, then per
// odd step a 3n+1 pass, an evaluate state, whole-word drops for the zero
// low words, a bit shift pass and a check; last the result is handed over.
// The number store is worked on one 64-bit word slice at a time.
// One item is worked on at a time; the next is taken once the result sits
// in the output register, even if the receiver has not yet taken it.
// A stalled receiver holds the result and its fields steady; the block
// then finishes the next item and waits with it until the register frees.
// Reset (rst_n low, asynchronous) clears control, the best record, the
// flagged count and sets shift_amount 0, step_limit 500000. Config writes
// (cfg_we, cfg_index, cfg_data) take effect at once; write only when idle.
`include "collatz_trajectory_checker_macros.svh"

module collatz_trajectory_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [cltz_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cltz_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [cltz_pkg::MULT_W-1:0]        start_multiplier,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [cltz_pkg::STATUS_W-1:0]      status,
    output logic [cltz_pkg::STEPS_W-1:0]       step_count,
    output logic [cltz_pkg::PEAK_W-1:0]        peak_bit_index,
    output logic [cltz_pkg::LIMIT_W-1:0]       best_steps,
    output logic [cltz_pkg::MULT_W-1:0]        best_multiplier,
    output logic [cltz_pkg::BEST_PEAK_W-1:0]   best_peak_bits,
    output logic [cltz_pkg::FLAG_W-1:0]        flagged_count
);
    import cltz_pkg::*;

    cmd_t              cmd;
    dstat_t            dstat;
    res_t              res;
    logic [KSH_W-1:0]  k;
    logic [MULT_W-1:0] m;
    logic              load;
    logic              res_free;

    // sequencer: owns the config registers and per-item counters
    cltz_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .start_multiplier (start_multiplier),
        .dstat            (dstat),
        .res_free         (res_free),
        .cmd              (cmd),
        .k                (k),
        .m                (m),
        .load             (load),
        .res              (res)
    );

    // 512-bit number as a ring of 64-bit words, one word per cycle
    cltz_digit u_digit (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .k     (k),
        .m     (m),
        .dstat (dstat)
    );

    // best record and output register
    cltz_stats u_stats (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (load),
        .res             (res),
        .res_free        (res_free),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .step_count      (step_count),
        .peak_bit_index  (peak_bit_index),
        .best_steps      (best_steps),
        .best_multiplier (best_multiplier),
        .best_peak_bits  (best_peak_bits),
        .flagged_count   (flagged_count)
    );

    // an accepted item keeps the block busy for at least the next cycle
    `CTC_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    // a result is only written into a free output register
    `CTC_ASSERT_IMP(a_load_when_free, clk, rst_n, load, !out_valid || out_ready)
    // a written result is presented in the following cycle
    `CTC_ASSERT_NXT(a_valid_after_load, clk, rst_n, load, out_valid)

endmodule

/* tb/sv/collatz_trajectory_checker_test.sv */
// Self-checking testbench for the collatz trajectory checker: directed and random start values.
`timescale 1ns / 1ps

module collatz_trajectory_checker_test;
    import cltz_pkg::*;

    // Hang guard, with a wide margin over the slowest legal run for long
    // trajectories and receiver stalls.
    localparam int CYCLE_LIMIT = 20_000_000;
    // Quiet cycles after the last result, longer than one capped item takes.
    localparam int TAIL_CYCLES = 2000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 50;

    localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

    // Flavours of random phase; each picks its own shift and step limit.
    typedef enum {
        MIX_NATURAL,    // small shift, no practical cap: trajectories run to one
        MIX_CAPPED,     // any shift, very low cap
        MIX_OVERFLOW,   // shift high enough that 3n+1 always runs out of bits
        MIX_TIGHT       // moderate shift, cap from 1 to 150
    } mix_t;

    // What one result transfer should carry.
    typedef struct {
        status_t                status;
        logic [STEPS_W-1:0]     steps;
        logic [PEAK_W-1:0]      peak;
        logic [LIMIT_W-1:0]     best_steps;
        logic [MULT_W-1:0]      best_mult;
        logic [BEST_PEAK_W-1:0] best_peak;
        logic [FLAG_W-1:0]      flagged;
    } trajectory_t;

    // ------------------------------------------------------------------
    // DUT and its inputs, all at known values from time zero
    // ------------------------------------------------------------------
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [MULT_W-1:0]      start_multiplier = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [STATUS_W-1:0]    status;
    logic [STEPS_W-1:0]     step_count;
    logic [PEAK_W-1:0]      peak_bit_index;
    logic [LIMIT_W-1:0]     best_steps;
    logic [MULT_W-1:0]      best_multiplier;
    logic [BEST_PEAK_W-1:0] best_peak_bits;
    logic [FLAG_W-1:0]      flagged_count;

    collatz_trajectory_checker dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .start_multiplier (start_multiplier),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .step_count       (step_count),
        .peak_bit_index   (peak_bit_index),
        .best_steps       (best_steps),
        .best_multiplier  (best_multiplier),
        .best_peak_bits   (best_peak_bits),
        .flagged_count    (flagged_count)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: register settings plus the running best record
    // ------------------------------------------------------------------
    logic [SHIFT_W-1:0]     shift_setting = '0;
    logic [LIMIT_W-1:0]     limit_setting = LIMIT_RESET;
    logic [LIMIT_W-1:0]     record_steps = '0;
    logic [MULT_W-1:0]      record_mult = '0;
    logic [BEST_PEAK_W-1:0] record_peak_bits = '0;
    logic [FLAG_W-1:0]      flag_tally = '0;

    trajectory_t awaited_trajectories[$];

    int fault_count  = 0;
    int results_seen = 0;
    int cycle_count  = 0;

    // Sender burst state: items left in the current burst before a gap.
    int burst_left = 0;

    // Receiver stall pattern state.
    bit ready_hi   = 1'b0;
    int ready_left = 0;

    // Walk one start value through the odd-step map at full 512-bit width,
    // then fold the outcome into the running record. Called once per
    // accepted input transfer, in order, so the record matches the block's.
    function automatic trajectory_t predict_trajectory(input logic [MULT_W-1:0] m);
        trajectory_t       r;
        logic [NUM_W-1:0]  n;
        logic [NUM_W+1:0]  t;     // two spare bits: 3n+1 can reach 3 * 2^512 - 2
        logic [31:0]       count;
        logic [31:0]       peak_idx;
        logic [31:0]       top;
        logic [31:0]       tz;
        int unsigned       k;
        int                i;
        bit                done;

        // Start value m * 2^(shift+1) - 1; a shift of 511 pushes every bit
        // of m out, and a zero product wraps to all ones.
        k = int'(shift_setting) + 1;
        n = ({{(NUM_W-MULT_W){1'b0}}, m} << k) - 1'b1;

        r.status = ST_ONE;
        count    = '0;
        peak_idx = '0;
        done     = 1'b0;
        while (!done && n != 1) begin
            t = {2'b00, n} + {1'b0, n, 1'b0} + 1'b1;
            if (t[NUM_W+1:NUM_W] != 2'b00) begin
                // carry out of the top: step count stays at the steps before
                r.status = ST_OVERFLOW;
                done     = 1'b1;
            end
            else begin
                n   = t[NUM_W-1:0];
                top = '0;
                tz  = '0;
                for (i = 0; i < NUM_W; i++)
                    if (n[i]) top = i;
                for (i = NUM_W - 1; i >= 0; i--)
                    if (n[i]) tz = i;
                if (top > peak_idx) peak_idx = top;
                n     = n >> tz;
                count = count + 1;
                if (count > limit_setting) begin
                    r.status = ST_LIMIT;
                    done     = 1'b1;
                end
            end
        end

        // Flagged items only bump the saturating tally; clean ones compete
        // for the record, strictly larger only, so ties keep the old holder.
        if (r.status != ST_ONE) begin
            if (flag_tally != '1) flag_tally = flag_tally + 1'b1;
        end
        else if (count > record_steps) begin
            record_steps     = count[LIMIT_W-1:0];
            record_mult      = m;
            record_peak_bits = peak_idx[BEST_PEAK_W-1:0] + 1'b1;
        end

        r.steps      = count[STEPS_W-1:0];
        r.peak       = peak_idx[PEAK_W-1:0];
        r.best_steps = record_steps;
        r.best_mult  = record_mult;
        r.best_peak  = record_peak_bits;
        r.flagged    = flag_tally;
        return r;
    endfunction

    // Mostly narrowed values, so that trajectories stay short, with a share
    // of full-width ones so every bit of the field gets exercised.
    function automatic logic [MULT_W-1:0] pick_multiplier();
        logic [MULT_W-1:0] m;
        int                w;

        m = {$urandom, $urandom};
        case ($urandom_range(0, 31))
            0:       m = '0;
            1:       m = 64'd1;
            2, 3, 4: ;
            default:
            begin
                w = $urandom_range(1, 64);
                if (w < 64) m = m & ((64'd1 << w) - 64'd1);
            end
        endcase
        return m;
    endfunction

    task automatic report_fault(input string msg);
        $display("[%0t] %s", $time, msg);
        fault_count++;
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report_fault($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                   results_seen, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Stimulus plumbing
    // ------------------------------------------------------------------

    // One input transfer. Valid goes up at a falling edge and is held with
    // the payload until a rising edge sees ready. Inside a burst valid is
    // left high so the next call simply swaps the payload; at the end of a
    // burst it is dropped for a random gap.
    task automatic send_multiplier(input logic [MULT_W-1:0] m);
        @(negedge clk);
        in_valid         <= 1'b1;
        start_multiplier <= m;
        do @(posedge clk); while (!in_ready);
        awaited_trajectories.push_back(predict_trajectory(m));
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge clk);
            // one burst in four is a long run with no idling at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 5);
        end
    endtask

    // Drop valid if a burst left it high; must follow a send directly.
    task automatic sender_rest();
        if (in_valid) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // Hold the sender off until every outstanding result has been taken.
    task automatic wait_results();
        sender_rest();
        while (awaited_trajectories.size() != 0) @(posedge clk);
    endtask

    // Register write, only ever with the block drained. Every item yields
    // a result, so an empty queue means the block is idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SHIFT_AMOUNT)
            shift_setting = data[SHIFT_W-1:0];
        else
            limit_setting = data[LIMIT_W-1:0];
    endtask

    // ------------------------------------------------------------------
    // Receiver: alternating ready and stall stretches, now and then a long
    // ready stretch so results also drain back to back.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (ready_left == 0) begin
            ready_hi   = !ready_hi;
            ready_left = ready_hi ? (($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                                  : $urandom_range(1, 8))
                                  : $urandom_range(1, 25);
        end
        else begin
            ready_left--;
        end
        out_ready <= ready_hi;
    end

    // ------------------------------------------------------------------
    // Result checker: each output transfer against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk) begin : result_check
        trajectory_t want;

        if (rst_n && out_valid && out_ready) begin
            if (awaited_trajectories.size() == 0) begin
                report_fault($sformatf("result transfer with nothing outstanding, status %0d",
                                       status));
            end
            else begin
                want = awaited_trajectories.pop_front();
                compare_field("status", status, want.status);
                compare_field("step_count", step_count, want.steps);
                compare_field("peak_bit_index", peak_bit_index, want.peak);
                compare_field("best_steps", best_steps, want.best_steps);
                compare_field("best_multiplier", best_multiplier, want.best_mult);
                compare_field("best_peak_bits", best_peak_bits, want.best_peak);
                compare_field("flagged_count", flagged_count, want.flagged);
            end
            results_seen++;
        end
    end

    // Hang guard.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings (shift 0, limit 500000). The first few items are
    // ordered so that the record starts at zero: a start of one cannot beat
    // it, 3 takes the record with two steps, and 13 ties it without
    // replacing the holder.
    task automatic test_reset_values();
        send_multiplier(64'd1);                 // start value already one
        send_multiplier(64'd2);                 // n = 3, takes the record
        send_multiplier(64'd7);                 // n = 13, same step count
        send_multiplier(64'd0);                 // wraps to all ones, overflows
        send_multiplier('1);
        send_multiplier(64'h8000_0000_0000_0000);
        send_multiplier(64'hAAAA_AAAA_AAAA_AAAA);
        send_multiplier(64'h5555_5555_5555_5555);
    endtask

    // Top of the shift range: at 511 the whole multiplier falls off the top,
    // at 510 only its low bit survives; both overflow on the first step.
    task automatic test_shift_extremes();
        write_register(REG_SHIFT_AMOUNT, CFG_DATA_W'(511));
        send_multiplier({$urandom, $urandom});
        send_multiplier(64'd0);
        write_register(REG_SHIFT_AMOUNT, CFG_DATA_W'(510));
        send_multiplier('1);
        send_multiplier(64'd1);
        write_register(REG_SHIFT_AMOUNT, CFG_DATA_W'(0));
    endtask

    // Step limit at zero (any step flags with a count of one), at one, and
    // at its maximum with short trajectories.
    task automatic test_limit_extremes();
        write_register(REG_STEP_LIMIT, CFG_DATA_W'(0));
        send_multiplier(64'd1);
        send_multiplier(64'd2);
        send_multiplier('1);
        write_register(REG_STEP_LIMIT, CFG_DATA_W'(1));
        send_multiplier(64'd2);
        send_multiplier(64'd3);
        send_multiplier(64'd5);
        write_register(REG_STEP_LIMIT, LIMIT_MAX);
        send_multiplier(64'd27);
        send_multiplier(64'hFFFF_FFFF);
        send_multiplier(64'd3);
    endtask

    // Random phases, each with fresh register settings; somewhere inside
    // each phase the sender waits for the block to drain completely.
    task automatic test_random_settings();
        int                 p;
        int                 i;
        int                 pause_at;
        mix_t               kind;
        logic [SHIFT_W-1:0] sh;
        logic [LIMIT_W-1:0] lim;

        for (p = 0; p < PHASES; p++) begin
            kind = mix_t'(p % 4);
            case (kind)
                MIX_NATURAL:
                begin
                    sh  = SHIFT_W'($urandom_range(0, 6));
                    lim = LIMIT_MAX;
                end
                MIX_CAPPED:
                begin
                    sh  = SHIFT_W'($urandom_range(0, 511));
                    lim = LIMIT_W'($urandom_range(0, 80));
                end
                MIX_OVERFLOW:
                begin
                    sh  = SHIFT_W'($urandom_range(330, 511));
                    lim = LIMIT_W'($urandom);
                end
                default:
                begin
                    sh  = SHIFT_W'($urandom_range(0, 40));
                    lim = LIMIT_W'($urandom_range(1, 150));
                end
            endcase
            write_register(REG_SHIFT_AMOUNT, CFG_DATA_W'(sh));
            write_register(REG_STEP_LIMIT, lim);
            pause_at = $urandom_range(5, PHASE_ITEMS - 5);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if (i == pause_at) wait_results();
                send_multiplier(pick_multiplier());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_shift_extremes();
        test_limit_extremes();
        test_random_settings();

        wait_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fault_count == 0 && awaited_trajectories.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
